@@ design/sitoa_pkg.sv @@
// ============================================================================
// sitoa_pkg
// Shared types and character constants for the signed integer to decimal
// text converter.
// ============================================================================
`default_nettype none

package sitoa_pkg;

    localparam int CODE_W = 6;

    localparam logic [CODE_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CODE_W-1:0] CHAR_MINUS = 6'd45;

    // pipeline tail to serializer handoff
    typedef struct packed {
        logic valid;
        logic neg;
    } hand_t;

endpackage

`default_nettype wire

@@ design/signed_int_to_decimal_ascii.sv @@
// ============================================================================
// signed_int_to_decimal_ascii
// Signed integer to decimal ASCII text, one character per strobe.
//
// A transaction is accepted when start is high and busy is low. Each number
// yields 1 to NUM_DIGITS+1 characters (1 to 11 at 32 bits): '-' for negative
// values, then the digits most significant first without leading zeros; the
// final one carries last_char. One character leaves per cycle on strobe and
// cannot be held off. The BCD pipeline has ceil(VALUE_BITS/4)+1 stages and
// takes a new value every cycle while the serializer keeps up; the serializer
// sets the sustained rate, loading a new number only as the current
// one ends; busy rises when a converted value waits at the pipeline tail.
// ============================================================================
`default_nettype none

module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic signed [VALUE_BITS-1:0] value,
    output logic                              busy,
    output logic                              strobe,
    output logic [sitoa_pkg::CODE_W-1:0]      char_code,
    output logic                              last_char
);
    import sitoa_pkg::*;

    localparam int NUM_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int IDX_W      = $clog2(NUM_DIGITS);

    hand_t                    hand;
    logic [NUM_DIGITS*4-1:0]  digits;
    logic [IDX_W-1:0]         msd;
    logic                     ser_ready;
    logic                     accept;

    assign accept = start && !busy;

    sitoa_bcd #(
        .VALUE_BITS (VALUE_BITS),
        .NUM_DIGITS (NUM_DIGITS),
        .IDX_W      (IDX_W)
    ) u_bcd (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .value     (value),
        .ser_ready (ser_ready),
        .busy      (busy),
        .hand      (hand),
        .digits    (digits),
        .msd       (msd)
    );

    sitoa_ser #(
        .NUM_DIGITS (NUM_DIGITS),
        .IDX_W      (IDX_W)
    ) u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .hand      (hand),
        .digits    (digits),
        .msd       (msd),
        .ready     (ser_ready),
        .strobe    (strobe),
        .char_code (char_code),
        .last_char (last_char)
    );

endmodule

`default_nettype wire

@@ design/sitoa_bcd.sv @@
// ============================================================================
// sitoa_bcd
// Pipelined binary to BCD conversion: sign and magnitude in the first stage,
// then four shift-add-3 steps per stage, leading digit search at the tail.
// ============================================================================
`default_nettype none

module sitoa_bcd #(
    parameter int VALUE_BITS = 32,
    parameter int NUM_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1,
    parameter int IDX_W      = $clog2(NUM_DIGITS)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic signed [VALUE_BITS-1:0] value,
    input  wire logic                        ser_ready,
    output logic                             busy,
    output sitoa_pkg::hand_t                 hand,
    output logic [NUM_DIGITS*4-1:0]          digits,
    output logic [IDX_W-1:0]                 msd
);
    import sitoa_pkg::*;

    localparam int BCD_W      = NUM_DIGITS * 4;
    localparam int STEPS      = 4;
    localparam int NUM_STAGES = (VALUE_BITS + STEPS - 1) / STEPS;
    localparam int PAD_W      = NUM_STAGES * STEPS;
    localparam int ACC_W      = BCD_W + PAD_W;

    function automatic logic [ACC_W-1:0] dabble(input logic [ACC_W-1:0] acc);
        logic [ACC_W-1:0] a;
        logic [3:0]       d;
        a = acc;
        for (int s = 0; s < STEPS; s++)
        begin
            for (int k = 0; k < NUM_DIGITS; k++)
            begin
                d = a[PAD_W + 4*k +: 4];
                if (d >= 4'd5)
                begin
                    a[PAD_W + 4*k +: 4] = d + 4'd3;
                end
            end
            a = a << 1;
        end
        return a;
    endfunction

    logic [NUM_STAGES:0]    vld_reg;
    logic [NUM_STAGES:0]    neg_reg;
    logic [ACC_W-1:0]       acc_reg [NUM_STAGES+1];
    logic [VALUE_BITS-1:0]  value_u;
    logic [VALUE_BITS-1:0]  mag;
    logic                   advance;

    assign value_u = unsigned'(value);
    assign mag     = value_u[VALUE_BITS-1] ? (~value_u + VALUE_BITS'(1)) : value_u;
    assign advance = !vld_reg[NUM_STAGES] || ser_ready;
    assign busy    = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[NUM_STAGES-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            acc_reg[0] <= {BCD_W'(0), PAD_W'(mag)};
            neg_reg[0] <= value_u[VALUE_BITS-1];
            for (int i = 1; i <= NUM_STAGES; i++)
            begin
                acc_reg[i] <= dabble(acc_reg[i-1]);
                neg_reg[i] <= neg_reg[i-1];
            end
        end
    end

    assign digits     = acc_reg[NUM_STAGES][PAD_W +: BCD_W];
    assign hand.valid = vld_reg[NUM_STAGES];
    assign hand.neg   = neg_reg[NUM_STAGES];

    // highest nonzero digit, zero when all digits are zero
    always_comb
    begin
        msd = '0;
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            if (digits[4*k +: 4] != 4'd0)
            begin
                msd = IDX_W'(k);
            end
        end
    end

endmodule

`default_nettype wire

@@ design/sitoa_ser.sv @@
// ============================================================================
// sitoa_ser
// Character serializer: emits an optional minus sign, then the digits from
// the leading nonzero one down, one character per cycle.
// ============================================================================
`default_nettype none

module sitoa_ser #(
    parameter int NUM_DIGITS = 10,
    parameter int IDX_W      = 4
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire sitoa_pkg::hand_t             hand,
    input  wire logic [NUM_DIGITS*4-1:0]      digits,
    input  wire logic [IDX_W-1:0]             msd,
    output logic                              ready,
    output logic                              strobe,
    output logic [sitoa_pkg::CODE_W-1:0]      char_code,
    output logic                              last_char
);
    import sitoa_pkg::*;

    logic              active_reg;
    logic              sign_pend_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [3:0]        digits_reg [NUM_DIGITS];
    logic              strobe_reg;
    logic [CODE_W-1:0] char_reg;
    logic              last_reg;
    logic              load;
    logic              at_last;
    logic [CODE_W-1:0] char_next;

    assign at_last   = !sign_pend_reg && (idx_reg == '0);
    assign ready     = !active_reg || at_last;
    assign load      = hand.valid && ready;
    assign char_next = sign_pend_reg ? CHAR_MINUS
                                     : (CHAR_ZERO + {2'b00, digits_reg[idx_reg]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            sign_pend_reg <= 1'b0;
            idx_reg       <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            strobe_reg <= active_reg;
            if (load)
            begin
                active_reg    <= 1'b1;
                sign_pend_reg <= hand.neg;
                idx_reg       <= msd;
            end
            else if (active_reg)
            begin
                if (sign_pend_reg)
                begin
                    sign_pend_reg <= 1'b0;
                end
                else if (idx_reg == '0)
                begin
                    active_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg - IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < NUM_DIGITS; k++)
            begin
                digits_reg[k] <= digits[4*k +: 4];
            end
        end
        char_reg <= char_next;
        last_reg <= at_last;
    end

    assign strobe    = strobe_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> (char_reg == CHAR_MINUS ||
                        (char_reg >= CHAR_ZERO && char_reg <= CHAR_ZERO + 6'd9)))
        else $error("character code out of range");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && char_reg == CHAR_MINUS) |-> !last_reg)
        else $error("minus sign flagged as last character");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && !last_reg) |=> strobe_reg)
        else $error("character run broken before last character");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (load && active_reg) |-> at_last)
        else $error("new number loaded over an unfinished run");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Testbench for signed_int_to_decimal_ascii: each accepted number is
// rendered to its expected decimal characters and checked in order against
// the strobed output. It covers edge values, a random mix of widths and
// signs with sender gaps, and a final back-to-back run.
// ============================================================================

module tb_top;

    import sitoa_pkg::*;

    localparam int VALUE_BITS  = 32;
    localparam int DRAIN_WAIT  = 40;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } char_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic signed [VALUE_BITS-1:0] value;
    logic                         busy;
    logic                         strobe;
    logic [CODE_W-1:0]            char_code;
    logic                         last_char;

    char_t pending_chars[$];
    int    mismatch_count;
    int    cycle_count;
    char_t head_char;

    signed_int_to_decimal_ascii #(
        .VALUE_BITS(VALUE_BITS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .value    (value),
        .busy     (busy),
        .strobe   (strobe),
        .char_code(char_code),
        .last_char(last_char)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // expected text of one number, sign first, digits most significant first
    function automatic void push_decimal_text(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS-1:0] mag;
        logic [3:0]            digits[0:23];
        int                    ndig;
        int                    i;
        char_t                 c;
        mag  = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
        ndig = 0;
        do
        begin
            digits[ndig] = 4'(mag % 10);
            mag          = mag / 10;
            ndig++;
        end while (mag != 0);
        if (v[VALUE_BITS-1])
        begin
            c.code = CHAR_MINUS;
            c.last = 1'b0;
            pending_chars.push_back(c);
        end
        for (i = ndig - 1; i >= 0; i--)
        begin
            c.code = CHAR_ZERO + digits[i];
            c.last = (i == 0);
            pending_chars.push_back(c);
        end
    endfunction

    // holds start and value until the transaction is taken
    task automatic send_value(input logic [VALUE_BITS-1:0] v);
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        push_decimal_text(v);
    endtask

    task automatic idle_sender(input int cycles);
        start <= 1'b0;
        value <= $urandom;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic maybe_idle(input int pct);
        if ($urandom_range(99, 0) < pct)
            idle_sender($urandom_range(8, 1));
    endtask

    function automatic logic [VALUE_BITS-1:0] random_value();
        longint lo;
        longint hi;
        longint mag;
        int     n;
        int     kind;
        kind = $urandom_range(9, 0);
        if (kind == 0)
            return '0;
        if (kind <= 2)
            return $urandom;
        if (kind == 3)
        begin
            case ($urandom_range(4, 0))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h8000_0001;
                3:       return 32'hFFFF_FFFF;
                default: return 32'h0000_0001;
            endcase
        end
        n  = $urandom_range(10, 1);
        lo = (n == 1) ? 0 : 10 ** (n - 1);
        hi = (n == 10) ? 64'd2147483647 : 10 ** n - 1;
        mag = $urandom_range(32'(hi), 32'(lo));
        if ($urandom_range(1, 0))
            mag = -mag;
        return mag[VALUE_BITS-1:0];
    endfunction

    task automatic test_directed_edges();
        logic [VALUE_BITS-1:0] edge_values[$];
        edge_values = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99,
                        32'd100, -32'sd7, 32'd123, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h8000_0001, 32'd1000000000, 32'd999999999,
                        -32'sd999999999, 32'd1234567890, 32'h5555_5555,
                        32'hAAAA_AAAA, -32'sd1000000000, 32'd0};
        foreach (edge_values[k])
        begin
            send_value(edge_values[k]);
            maybe_idle(40);
        end
    endtask

    task automatic test_random_mix();
        int pct;
        repeat (16)
        begin
            case ($urandom_range(2, 0))
                0:       pct = 0;
                1:       pct = 25;
                default: pct = 50;
            endcase
            repeat (16)
            begin
                send_value(random_value());
                maybe_idle(pct);
            end
        end
    endtask

    task automatic test_back_to_back();
        repeat (40) send_value(random_value());
    endtask

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (pending_chars.size() == 0)
                report_mismatch($sformatf("unexpected char %0d last %0b",
                                          char_code, last_char));
            else
            begin
                head_char = pending_chars.pop_front();
                if (char_code !== head_char.code)
                    report_mismatch($sformatf("char_code %0d, expected %0d",
                                              char_code, head_char.code));
                if (last_char !== head_char.last)
                    report_mismatch($sformatf("last_char %0b, expected %0b",
                                              last_char, head_char.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL signed_int_to_decimal_ascii");
            $finish;
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        value          = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_random_mix();
        test_back_to_back();

        start <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS signed_int_to_decimal_ascii");
        else
            $display("FAIL signed_int_to_decimal_ascii");
        $finish;
    end

endmodule
